// ===== rtl/dbed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbed_pkg: shared types and constants of the DDS beep envelope DAC
// Configuration record, register indexes, sequencer states, DAC control bits
// and the fixed-point constants used to build the sine table.
// ----------------------------------------------------------------------------
package dbed_pkg;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [15:0] attack_length;
    logic [15:0] decay_length;
    logic [15:0] beep_length;
    logic [15:0] silence_length;
    logic [15:0] attack_step;
    logic [15:0] decay_step;
    logic        channel_b;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_PHASE_STEP     = 3'd0,
    REG_ATTACK_LENGTH  = 3'd1,
    REG_DECAY_LENGTH   = 3'd2,
    REG_BEEP_LENGTH    = 3'd3,
    REG_SILENCE_LENGTH = 3'd4,
    REG_ATTACK_STEP    = 3'd5,
    REG_DECAY_STEP     = 3'd6,
    REG_CHANNEL_B      = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SILENT,
    ST_INDEX,
    ST_ROM,
    ST_AMP,
    ST_SCALE,
    ST_SAT,
    ST_OUT_SAMPLE,
    ST_OUT_END
  } state_t;

  localparam logic [31:0] RST_PHASE_STEP     = 32'd34359738;
  localparam logic [15:0] RST_ATTACK_LENGTH  = 16'd250;
  localparam logic [15:0] RST_DECAY_LENGTH   = 16'd250;
  localparam logic [15:0] RST_BEEP_LENGTH    = 16'd10500;
  localparam logic [15:0] RST_SILENCE_LENGTH = 16'd25000;
  localparam logic [15:0] RST_ATTACK_STEP    = 16'd131;
  localparam logic [15:0] RST_DECAY_STEP     = 16'd131;
  localparam logic        RST_CHANNEL_B      = 1'b1;

  localparam logic [3:0]  CTRL_A      = 4'h3;
  localparam logic [3:0]  CTRL_B      = 4'hB;
  localparam logic [11:0] MID_SAMPLE  = 12'd2048;
  localparam logic [11:0] MAX_SAMPLE  = 12'd4095;
  localparam logic [16:0] AMP_MAX     = 17'd32768;

  localparam logic [63:0] Q60_PI      = 64'h3243F6A8885A308D;
  localparam logic [63:0] Q60_TWO_PI  = 64'h6487ED5110B4611A;
  localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;
  localparam logic [63:0] ROM_SCALE   = 64'd67076096;

  localparam int unsigned TAYLOR_TERMS = 14;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
  };

endpackage

// ===== rtl/dds_beep_envelope_dac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_beep_envelope_dac: DDS tone generator with attack/decay envelope
// One input item is one audio tick; it yields zero, one or two DAC words.
//
// channel | ports                          | payload
// in      | in_tvalid/in_tready            | tdata: loudness_scale, delay_value
//         |                                | tuser: load_delay
// out     | out_tvalid/out_tready          | tdata: dac_word, tlast: is_last
// cfg     | cfg_psel/penable/pwrite/pready | 8 registers at byte address 4*i
//
// Silent tick: SILENT. Sounding tick: INDEX, ROM, AMP, SCALE, SAT, then one
// output state per DAC word that waits for a free output register; one shared
// 33x17 multiplier forms table index, envelope and loudness products in turn.
// in_tready is high only in the idle state; the output register holds a word
// until taken while the next item is accepted. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module dds_beep_envelope_dac #(
  parameter int SINE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] loudness_scale, [23:16] delay_value
  input  logic        in_tuser,   // [0] load_delay
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] dac_word
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(SINE_DEPTH);

  dbed_pkg::cfg_t     cfg;
  dbed_pkg::state_t   state_r, state_nxt;

  logic               beeping_r, beeping_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic [31:0]        phase_r, phase_nxt;
  logic [15:0]        amp_r, amp_nxt;
  logic [7:0]         skip_r, skip_nxt;
  logic [15:0]        scale_r;
  logic [15:0]        decay_start_r;
  logic signed [49:0] prod_r;
  logic [11:0]        sample_r;
  logic               end_r;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_data_r;
  logic               out_last_r;

  logic               in_acc;
  logic               out_free;
  logic               load_out;
  logic               rom_rd;
  logic               prod_ld;
  logic signed [27:0] rom_q;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic [31:0]        phase_sum;
  logic [16:0]        tick_inc;
  logic               beep_done;
  logic               silence_done;
  logic               emit;
  logic signed [15:0] b_off;
  logic [11:0]        sample_c;
  logic [16:0]        amp_up;
  logic [15:0]        amp_env;
  logic [3:0]         ctrl;
  logic [15:0]        out_data_c;

  dbed_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dbed_sine_rom #(.SINE_DEPTH(SINE_DEPTH)) u_rom (
    .clk     (clk),
    .rd_en   (rom_rd),
    .addr    (prod_r[32 +: IDX_W]),
    .rd_data (rom_q)
  );

  assign phase_sum    = phase_r + cfg.phase_step;
  assign tick_inc     = {1'b0, tick_r} + 17'd1;
  assign beep_done    = tick_inc >= {1'b0, cfg.beep_length};
  assign silence_done = tick_inc >= {1'b0, cfg.silence_length};
  assign emit         = (skip_r == 8'd0);
  assign out_free     = !out_valid_r || out_tready;
  assign in_acc       = in_tvalid && in_tready;
  assign ctrl         = cfg.channel_b ? dbed_pkg::CTRL_B : dbed_pkg::CTRL_A;
  assign mul_p        = mul_a * mul_b;

  always_comb begin
    unique case (state_r)
      dbed_pkg::ST_INDEX: begin
        mul_a = {1'b0, phase_sum};
        mul_b = 17'(SINE_DEPTH);
      end
      dbed_pkg::ST_SCALE: begin
        mul_a = {{20{prod_r[42]}}, prod_r[42:30]};
        mul_b = {1'b0, scale_r};
      end
      default: begin
        mul_a = {{5{rom_q[27]}}, rom_q};
        mul_b = {1'b0, amp_r};
      end
    endcase
  end

  always_comb begin
    b_off = {prod_r[29], prod_r[29:15]} + 16'sd2048;
    if (b_off < 16'sd0)                        sample_c = 12'd0;
    else if (b_off > 16'sd4095)                sample_c = dbed_pkg::MAX_SAMPLE;
    else                                       sample_c = b_off[11:0];
  end

  always_comb begin
    amp_up = {1'b0, amp_r} + {1'b0, cfg.attack_step};
    if (tick_r < cfg.attack_length) begin
      amp_env = (amp_up > dbed_pkg::AMP_MAX) ? dbed_pkg::AMP_MAX[15:0] : amp_up[15:0];
    end else if (tick_r >= decay_start_r) begin
      amp_env = (amp_r > cfg.decay_step) ? amp_r - cfg.decay_step : 16'd0;
    end else begin
      amp_env = amp_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dbed_pkg::ST_IDLE:
        if (in_acc) state_nxt = beeping_r ? dbed_pkg::ST_INDEX : dbed_pkg::ST_SILENT;
      dbed_pkg::ST_SILENT: state_nxt = dbed_pkg::ST_IDLE;
      dbed_pkg::ST_INDEX:  state_nxt = dbed_pkg::ST_ROM;
      dbed_pkg::ST_ROM:    state_nxt = dbed_pkg::ST_AMP;
      dbed_pkg::ST_AMP:    state_nxt = dbed_pkg::ST_SCALE;
      dbed_pkg::ST_SCALE:  state_nxt = dbed_pkg::ST_SAT;
      dbed_pkg::ST_SAT: begin
        if (emit)           state_nxt = dbed_pkg::ST_OUT_SAMPLE;
        else if (beep_done) state_nxt = dbed_pkg::ST_OUT_END;
        else                state_nxt = dbed_pkg::ST_IDLE;
      end
      dbed_pkg::ST_OUT_SAMPLE:
        if (out_free) state_nxt = end_r ? dbed_pkg::ST_OUT_END : dbed_pkg::ST_IDLE;
      dbed_pkg::ST_OUT_END:
        if (out_free) state_nxt = dbed_pkg::ST_IDLE;
      default: state_nxt = dbed_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    rom_rd     = 1'b0;
    prod_ld    = 1'b0;
    load_out   = 1'b0;
    out_data_c = {ctrl, dbed_pkg::MID_SAMPLE};
    unique case (state_r)
      dbed_pkg::ST_IDLE:  in_tready = 1'b1;
      dbed_pkg::ST_INDEX: prod_ld   = 1'b1;
      dbed_pkg::ST_ROM:   rom_rd    = 1'b1;
      dbed_pkg::ST_AMP:   prod_ld   = 1'b1;
      dbed_pkg::ST_SCALE: prod_ld   = 1'b1;
      dbed_pkg::ST_OUT_SAMPLE: begin
        load_out   = out_free;
        out_data_c = {ctrl, sample_r};
      end
      dbed_pkg::ST_OUT_END: load_out = out_free;
      default: ;
    endcase
  end

  // tone and envelope state
  always_comb begin
    beeping_nxt = beeping_r;
    tick_nxt    = tick_r;
    phase_nxt   = phase_r;
    amp_nxt     = amp_r;
    skip_nxt    = skip_r;
    unique case (state_r)
      dbed_pkg::ST_IDLE:
        if (in_acc && in_tuser) skip_nxt = in_tdata[23:16];
      dbed_pkg::ST_SILENT: begin
        if (silence_done) begin
          beeping_nxt = 1'b1;
          tick_nxt    = 16'd0;
          amp_nxt     = 16'd0;
        end else begin
          tick_nxt = tick_inc[15:0];
        end
      end
      dbed_pkg::ST_INDEX: phase_nxt = phase_sum;
      dbed_pkg::ST_SAT: begin
        if (!emit) skip_nxt = skip_r - 8'd1;
        if (beep_done) begin
          beeping_nxt = 1'b0;
          tick_nxt    = 16'd0;
          amp_nxt     = 16'd0;
        end else begin
          tick_nxt = tick_inc[15:0];
          amp_nxt  = amp_env;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbed_pkg::ST_IDLE;
      beeping_r   <= 1'b1;
      tick_r      <= 16'd0;
      phase_r     <= 32'd0;
      amp_r       <= 16'd0;
      skip_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      beeping_r   <= beeping_nxt;
      tick_r      <= tick_nxt;
      phase_r     <= phase_nxt;
      amp_r       <= amp_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) scale_r <= in_tdata[15:0];
    if (prod_ld) prod_r <= mul_p;
    if (rom_rd) begin
      decay_start_r <= (cfg.beep_length > cfg.decay_length) ?
                       cfg.beep_length - cfg.decay_length : 16'd0;
    end
    if (state_r == dbed_pkg::ST_SAT) begin
      sample_r <= sample_c;
      end_r    <= beep_done;
    end
    if (load_out) begin
      out_data_r <= out_data_c;
      out_last_r <= (state_r == dbed_pkg::ST_OUT_END) || !end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/dbed_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbed_regs: configuration register file
// APB-style slave holding tone, envelope, timing and channel settings.
// ----------------------------------------------------------------------------
module dbed_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output dbed_pkg::cfg_t    cfg
);

  dbed_pkg::cfg_t   cfg_r;
  dbed_pkg::cfg_t   cfg_nxt;
  dbed_pkg::cfg_idx_t idx;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = dbed_pkg::cfg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        dbed_pkg::REG_PHASE_STEP:     cfg_nxt.phase_step     = cfg_pwdata;
        dbed_pkg::REG_ATTACK_LENGTH:  cfg_nxt.attack_length  = cfg_pwdata[15:0];
        dbed_pkg::REG_DECAY_LENGTH:   cfg_nxt.decay_length   = cfg_pwdata[15:0];
        dbed_pkg::REG_BEEP_LENGTH:    cfg_nxt.beep_length    = cfg_pwdata[15:0];
        dbed_pkg::REG_SILENCE_LENGTH: cfg_nxt.silence_length = cfg_pwdata[15:0];
        dbed_pkg::REG_ATTACK_STEP:    cfg_nxt.attack_step    = cfg_pwdata[15:0];
        dbed_pkg::REG_DECAY_STEP:     cfg_nxt.decay_step     = cfg_pwdata[15:0];
        dbed_pkg::REG_CHANNEL_B:      cfg_nxt.channel_b      = cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dbed_pkg::REG_PHASE_STEP:     cfg_prdata = cfg_r.phase_step;
      dbed_pkg::REG_ATTACK_LENGTH:  cfg_prdata = {16'd0, cfg_r.attack_length};
      dbed_pkg::REG_DECAY_LENGTH:   cfg_prdata = {16'd0, cfg_r.decay_length};
      dbed_pkg::REG_BEEP_LENGTH:    cfg_prdata = {16'd0, cfg_r.beep_length};
      dbed_pkg::REG_SILENCE_LENGTH: cfg_prdata = {16'd0, cfg_r.silence_length};
      dbed_pkg::REG_ATTACK_STEP:    cfg_prdata = {16'd0, cfg_r.attack_step};
      dbed_pkg::REG_DECAY_STEP:     cfg_prdata = {16'd0, cfg_r.decay_step};
      dbed_pkg::REG_CHANNEL_B:      cfg_prdata = {31'd0, cfg_r.channel_b};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step     <= dbed_pkg::RST_PHASE_STEP;
      cfg_r.attack_length  <= dbed_pkg::RST_ATTACK_LENGTH;
      cfg_r.decay_length   <= dbed_pkg::RST_DECAY_LENGTH;
      cfg_r.beep_length    <= dbed_pkg::RST_BEEP_LENGTH;
      cfg_r.silence_length <= dbed_pkg::RST_SILENCE_LENGTH;
      cfg_r.attack_step    <= dbed_pkg::RST_ATTACK_STEP;
      cfg_r.decay_step     <= dbed_pkg::RST_DECAY_STEP;
      cfg_r.channel_b      <= dbed_pkg::RST_CHANNEL_B;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/dbed_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbed_sine_rom: constant sine table with registered read
// Entries are 2047 * 2^15 * sin(2*pi*k/SINE_DEPTH), truncated toward zero,
// built at elaboration from a Q60 Taylor series.
// ----------------------------------------------------------------------------
module dbed_sine_rom #(
  parameter int SINE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(SINE_DEPTH)-1:0] addr,
  output logic signed [27:0]            rd_data
);

  localparam logic [63:0] DEPTH64 = 64'(SINE_DEPTH);

  function automatic logic [63:0] mul_shr60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic signed [27:0] sine_value(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        sum;
    logic [63:0]        mag;
    logic               neg;
    logic signed [27:0] m;
    x = (dbed_pkg::Q60_TWO_PI / DEPTH64) * k
        + ((dbed_pkg::Q60_TWO_PI % DEPTH64) * k) / DEPTH64;
    neg = 1'b0;
    if (x > dbed_pkg::Q60_PI) begin
      x   = dbed_pkg::Q60_TWO_PI - x;
      neg = 1'b1;
    end
    if (x > dbed_pkg::Q60_HALF_PI) x = dbed_pkg::Q60_PI - x;
    x2   = mul_shr60(x, x);
    term = x;
    sum  = x;
    for (int i = 1; i <= dbed_pkg::TAYLOR_TERMS; i++) begin
      term = mul_shr60(term, x2) / dbed_pkg::TAYLOR_DIV[i-1];
      if (i % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    mag = mul_shr60(sum + 64'd256, dbed_pkg::ROM_SCALE);
    if (mag > dbed_pkg::ROM_SCALE) mag = dbed_pkg::ROM_SCALE;
    m = 28'(mag);
    return neg ? -m : m;
  endfunction

  logic signed [27:0] tab [SINE_DEPTH];

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_tab
    localparam logic signed [27:0] VAL = sine_value(64'(g));
    assign tab[g] = VAL;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tab[addr];
    end
  end

endmodule

// ===== verif/tb_dds_beep_envelope_dac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dds_beep_envelope_dac: self-checking bench for the DDS beep envelope DAC
// Sends audio ticks on the input stream and reprograms the tone registers over
// APB between phases. A tone predictor with its own sine table queues the DAC
// words each tick should produce, and every word leaving the block is checked
// in order. Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module tb_dds_beep_envelope_dac;

  localparam int          SINE_LEN    = 256;
  localparam int          SINE_IDX_W  = $clog2(SINE_LEN);
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          SETTLE      = 16;
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] SINE_GAIN   = 64'd67076096;
  localparam int unsigned ENV_FULL    = 32768;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [15:0] word;
    logic        last;
  } dac_word_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;  // [15:0] loudness_scale, [23:16] delay_value
  logic        in_tuser    = 1'b0; // [0] load_delay
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;         // [15:0] dac_word
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // tone predictor state
  dbed_pkg::cfg_t tone_cfg;
  int          sine_table [SINE_LEN];
  logic        beep_on;
  logic [15:0] tick_cnt;
  logic [31:0] phase_acc;
  int unsigned env_amp;
  logic [7:0]  skip_left;
  dac_word_t   dac_words_due [$];

  int errors    = 0;
  int cycle_cnt = 0;
  int send_pct  = 0;
  int stall_pct = 0;

  dds_beep_envelope_dac #(.SINE_DEPTH(SINE_LEN)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_dac
    dac_word_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (dac_words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected DAC word, expected none, got %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        due = dac_words_due.pop_front();
        if (out_tdata !== due.word) begin
          errors++;
          $display("%0t: dac_word expected %h got %h", $time, due.word, out_tdata);
        end
        if (out_tlast !== due.last) begin
          errors++;
          $display("%0t: is_last expected %b got %b", $time, due.last, out_tlast);
        end
      end
    end
  end

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series of sin in Q60, scaled to 2047 * 2^15 and truncated
  function automatic int sine_entry(input int k);
    logic [63:0] x, x2, term, sum, mag, kx;
    logic        neg;
    int          i;
    neg = 1'b0;
    kx = 64'(k);
    x = (TWO_PI_Q60 / 64'(SINE_LEN)) * kx + ((TWO_PI_Q60 % 64'(SINE_LEN)) * kx) / 64'(SINE_LEN);
    if (x > PI_Q60) begin
      x = TWO_PI_Q60 - x;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q60) x = PI_Q60 - x;
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (i = 1; i <= 14; i++) begin
      term = mul_q60(term, x2) / (64'(2 * i) * 64'(2 * i + 1));
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    mag = mul_q60(sum + 64'd256, SINE_GAIN);
    if (mag > SINE_GAIN) mag = SINE_GAIN;
    return neg ? -int'(mag) : int'(mag);
  endfunction

  task automatic predict_dac_words(input logic [15:0] scale, input logic ld,
                                   input logic [7:0] dval);
    logic [15:0] ctrl;
    logic [16:0] tick_next;
    logic [15:0] decay_start;
    logic [63:0] idx;
    longint      a, b;
    logic        ending;
    dac_word_t   w;
    ctrl = {tone_cfg.channel_b ? dbed_pkg::CTRL_B : dbed_pkg::CTRL_A, 12'h000};
    if (ld) skip_left = dval;
    if (!beep_on) begin
      tick_next = {1'b0, tick_cnt} + 17'd1;
      if (tick_next >= {1'b0, tone_cfg.silence_length}) begin
        beep_on = 1'b1;
        tick_next = '0;
        env_amp = 0;
      end
      tick_cnt = tick_next[15:0];
      return;
    end
    phase_acc = phase_acc + tone_cfg.phase_step;
    idx = ({32'd0, phase_acc} * 64'(SINE_LEN)) >> 32;
    if (idx >= 64'(SINE_LEN)) idx = 64'(SINE_LEN - 1);
    a = (longint'(env_amp) * longint'(sine_table[idx[SINE_IDX_W-1:0]])) >>> 15;
    a = a >>> 15;
    b = ((longint'(scale) * a) >>> 15) + 2048;
    if (b > 4095) b = 4095;
    else if (b < 0) b = 0;

    decay_start = (tone_cfg.beep_length > tone_cfg.decay_length) ?
                  tone_cfg.beep_length - tone_cfg.decay_length : 16'd0;
    if (tick_cnt < tone_cfg.attack_length) begin
      env_amp = env_amp + tone_cfg.attack_step;
      if (env_amp > ENV_FULL) env_amp = ENV_FULL;
    end else if (tick_cnt >= decay_start) begin
      env_amp = (env_amp > tone_cfg.decay_step) ? env_amp - tone_cfg.decay_step : 0;
    end

    tick_next = {1'b0, tick_cnt} + 17'd1;
    ending = (tick_next >= {1'b0, tone_cfg.beep_length});
    if (skip_left != 0) begin
      skip_left--;
    end else begin
      w.word = ctrl | {4'h0, b[11:0]};
      w.last = !ending;
      dac_words_due.push_back(w);
    end
    if (ending) begin
      beep_on = 1'b0;
      tick_next = '0;
      env_amp = 0;
      w.word = ctrl | {4'h0, dbed_pkg::MID_SAMPLE};
      w.last = 1'b1;
      dac_words_due.push_back(w);
    end
    tick_cnt = tick_next[15:0];
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        send_pct = 82;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        send_pct = 0;
        stall_pct = 82;
      end
      default: begin
        send_pct = 24;
        stall_pct = 24;
      end
    endcase
  endtask

  task automatic cfg_write(input dbed_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      dbed_pkg::REG_PHASE_STEP:     tone_cfg.phase_step = val;
      dbed_pkg::REG_ATTACK_LENGTH:  tone_cfg.attack_length = val[15:0];
      dbed_pkg::REG_DECAY_LENGTH:   tone_cfg.decay_length = val[15:0];
      dbed_pkg::REG_BEEP_LENGTH:    tone_cfg.beep_length = val[15:0];
      dbed_pkg::REG_SILENCE_LENGTH: tone_cfg.silence_length = val[15:0];
      dbed_pkg::REG_ATTACK_STEP:    tone_cfg.attack_step = val[15:0];
      dbed_pkg::REG_DECAY_STEP:     tone_cfg.decay_step = val[15:0];
      dbed_pkg::REG_CHANNEL_B:      tone_cfg.channel_b = val[0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input logic [15:0] scale, input logic ld, input logic [7:0] dval);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dval, scale};
    in_tuser <= ld;
    do @(posedge clk); while (!in_tready);
    predict_dac_words(scale, ld, dval);
  endtask

  task automatic send_random_tick();
    logic [15:0] scale;
    logic        ld;
    logic [7:0]  dval;
    case ($urandom_range(7))
      0: scale = 16'd0;
      1: scale = 16'd32768;
      2: scale = 16'hFFFF;
      default: scale = 16'($urandom_range(65535));
    endcase
    ld = ($urandom_range(9) == 0);
    dval = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
    send_tick(scale, ld, dval);
  endtask

  // hold off until every DAC word is out, then let the block settle
  task automatic wait_dac_idle();
    in_tvalid <= 1'b0;
    while (dac_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_random_tones();
    logic [31:0] v;
    v = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0) : $urandom();
    cfg_write(dbed_pkg::REG_PHASE_STEP, v);
    cfg_write(dbed_pkg::REG_ATTACK_LENGTH,
              ($urandom_range(7) == 0) ? 65535 : $urandom_range(20));
    cfg_write(dbed_pkg::REG_DECAY_LENGTH,
              ($urandom_range(7) == 0) ? 65535 : $urandom_range(20));
    if ($urandom_range(15) == 0) v = 0;
    else if ($urandom_range(15) == 0) v = 65535;
    else v = $urandom_range(40, 1);
    cfg_write(dbed_pkg::REG_BEEP_LENGTH, v);
    cfg_write(dbed_pkg::REG_SILENCE_LENGTH,
              ($urandom_range(15) == 0) ? 0 : $urandom_range(8, 1));
    case ($urandom_range(7))
      0: v = 0;
      1: v = 32768;
      default: v = $urandom_range(32768);
    endcase
    cfg_write(dbed_pkg::REG_ATTACK_STEP, v);
    case ($urandom_range(7))
      0: v = 0;
      1: v = 32768;
      default: v = $urandom_range(32768);
    endcase
    cfg_write(dbed_pkg::REG_DECAY_STEP, v);
    cfg_write(dbed_pkg::REG_CHANNEL_B, $urandom_range(1));
  endtask

  task automatic test_scale_and_delay();
    set_idle(IDLE_NONE);
    send_tick(16'd0, 1'b0, 8'd0);
    send_tick(16'd32768, 1'b0, 8'd0);
    send_tick(16'hFFFF, 1'b0, 8'd0);
    send_tick(16'd1, 1'b0, 8'd0);
    send_tick(16'd12345, 1'b1, 8'd255);
    send_tick(16'd32768, 1'b1, 8'd0);
    send_tick(16'd32768, 1'b0, 8'd0);
  endtask

  task automatic test_beep_boundaries();
    wait_dac_idle();
    cfg_write(dbed_pkg::REG_BEEP_LENGTH, 3);
    cfg_write(dbed_pkg::REG_SILENCE_LENGTH, 2);
    cfg_write(dbed_pkg::REG_ATTACK_LENGTH, 1);
    cfg_write(dbed_pkg::REG_ATTACK_STEP, 32768);
    cfg_write(dbed_pkg::REG_DECAY_LENGTH, 1);
    cfg_write(dbed_pkg::REG_DECAY_STEP, 32768);
    cfg_write(dbed_pkg::REG_PHASE_STEP, 32'h4000_0000);
    cfg_write(dbed_pkg::REG_CHANNEL_B, 0);
    // running count is past the shortened beep: ends on this tick
    send_tick(16'hFFFF, 1'b0, 8'd0);
    send_tick(16'd0, 1'b0, 8'd0);
    send_tick(16'd0, 1'b0, 8'd0);
    send_tick(16'd32768, 1'b0, 8'd0);
    send_tick(16'd32768, 1'b0, 8'd0);
    // skipped sample on the last beep tick: midpoint word only
    send_tick(16'd32768, 1'b1, 8'd1);
    send_tick(16'd0, 1'b0, 8'd0);
    send_tick(16'd0, 1'b0, 8'd0);
    send_tick(16'hFFFF, 1'b0, 8'd0);
    send_tick(16'hFFFF, 1'b0, 8'd0);
    send_tick(16'hFFFF, 1'b0, 8'd0);
  endtask

  task automatic test_zero_lengths();
    wait_dac_idle();
    cfg_write(dbed_pkg::REG_BEEP_LENGTH, 0);
    cfg_write(dbed_pkg::REG_SILENCE_LENGTH, 0);
    cfg_write(dbed_pkg::REG_ATTACK_LENGTH, 0);
    cfg_write(dbed_pkg::REG_ATTACK_STEP, 0);
    cfg_write(dbed_pkg::REG_DECAY_STEP, 0);
    cfg_write(dbed_pkg::REG_CHANNEL_B, 1);
    send_tick(16'd20000, 1'b0, 8'd0);
    send_tick(16'd20000, 1'b0, 8'd0);
    send_tick(16'd40000, 1'b1, 8'd1);
    send_tick(16'd40000, 1'b0, 8'd0);
  endtask

  task automatic test_long_lengths();
    set_idle(IDLE_BOTH);
    wait_dac_idle();
    cfg_write(dbed_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_write(dbed_pkg::REG_ATTACK_LENGTH, 65535);
    cfg_write(dbed_pkg::REG_DECAY_LENGTH, 65535);
    cfg_write(dbed_pkg::REG_BEEP_LENGTH, 65535);
    cfg_write(dbed_pkg::REG_ATTACK_STEP, 32768);
    cfg_write(dbed_pkg::REG_DECAY_STEP, 32768);
    repeat (30) send_random_tick();
    wait_dac_idle();
    cfg_write(dbed_pkg::REG_SILENCE_LENGTH, 65535);
    cfg_write(dbed_pkg::REG_BEEP_LENGTH, 5);
    repeat (11) send_random_tick();
    wait_dac_idle();
    // shrink the silence below the running count: the next tick ends the silence
    cfg_write(dbed_pkg::REG_SILENCE_LENGTH, 3);
    cfg_write(dbed_pkg::REG_BEEP_LENGTH, 12);
    cfg_write(dbed_pkg::REG_ATTACK_LENGTH, 4);
    cfg_write(dbed_pkg::REG_DECAY_LENGTH, 4);
    cfg_write(dbed_pkg::REG_ATTACK_STEP, 9000);
    cfg_write(dbed_pkg::REG_DECAY_STEP, 9000);
    repeat (20) send_random_tick();
  endtask

  task automatic test_random_tones();
    int p;
    for (p = 0; p < 8; p++) begin
      wait_dac_idle();
      set_idle(idle_mode_t'(p % 4));
      program_random_tones();
      repeat (170) send_random_tick();
    end
  endtask

  initial begin : main
    int k;
    for (k = 0; k < SINE_LEN; k++) sine_table[k] = sine_entry(k);
    tone_cfg.phase_step = dbed_pkg::RST_PHASE_STEP;
    tone_cfg.attack_length = dbed_pkg::RST_ATTACK_LENGTH;
    tone_cfg.decay_length = dbed_pkg::RST_DECAY_LENGTH;
    tone_cfg.beep_length = dbed_pkg::RST_BEEP_LENGTH;
    tone_cfg.silence_length = dbed_pkg::RST_SILENCE_LENGTH;
    tone_cfg.attack_step = dbed_pkg::RST_ATTACK_STEP;
    tone_cfg.decay_step = dbed_pkg::RST_DECAY_STEP;
    tone_cfg.channel_b = dbed_pkg::RST_CHANNEL_B;
    beep_on = 1'b1;
    tick_cnt = '0;
    phase_acc = '0;
    env_amp = 0;
    skip_left = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_scale_and_delay();
    test_beep_boundaries();
    test_zero_lengths();
    test_long_lengths();
    test_random_tones();
    wait_dac_idle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
